// File: sv/allocation_record_table_defines.svh
// ----------------------------------------------------------------------------
// Allocation record table: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_RECORD_TABLE_DEFINES_SVH
`define ALLOCATION_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication.
`define ART_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocation_record_table: same-cycle check failed");

// Next-cycle implication.
`define ART_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocation_record_table: next-cycle check failed");

`endif

// File: sv/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Types and constants shared by the allocation record table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package art_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned SLOT_W    = 7;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] REC_OFFSET = ADDR_W'(8);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TINY_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TINY_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_END   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              size_class;
    logic [ADDR_W-1:0] user_addr;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot_index;
    logic              in_range;
    logic [ADDR_W-1:0] record_addr;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic start;
    logic scan_en;
    logic commit;
    logic set_fail;
    logic load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic add_zero;
    logic hit;
    logic miss_end;
  } stat_t;

endpackage

// File: sv/allocation_record_table.sv
// ----------------------------------------------------------------------------
// allocation_record_table
// Tiny/small allocation record tracker with first-free add and first-match
// remove, plus a data-range check on every transaction.
// ----------------------------------------------------------------------------
// One transaction at a time. An add or remove scans the chosen class's
// single-port slot memory one slot per cycle, up to N slots, N being that
// class's slot count (TINY_SLOTS or SMALL_SLOTS); it ends early at the
// first free slot (add) or first match (remove). Range checks and adds of
// address zero do not scan. The result sits in an output register, so a new
// transaction is taken while it waits. After reset a clearing pass over
// max(TINY_SLOTS, SMALL_SLOTS) slots empties both tables; in_ready_o stays
// low during it, configuration writes are taken.
`timescale 1ns / 1ps

module allocation_record_table #(
  parameter int unsigned TINY_SLOTS  = 128,
  parameter int unsigned SMALL_SLOTS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [art_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [art_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  art_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output art_pkg::out_t                 out_data_o
);
  import art_pkg::*;

  `include "allocation_record_table_defines.svh"

  ctrl_t ctrl;
  stat_t stat;

  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  art_datapath #(
    .TINY_SLOTS  (TINY_SLOTS),
    .SMALL_SLOTS (SMALL_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  `ART_ASSERT_SAME(a_hit_miss_excl, stat.hit, !stat.miss_end)
  `ART_ASSERT_SAME(a_fail_slot_zero, out_valid_o && out_data_o.status, out_data_o.slot_index == '0)
  `ART_ASSERT_SAME(a_range_addr_zero, out_valid_o && !out_data_o.in_range, out_data_o.record_addr == '0)
  `ART_ASSERT_NEXT(a_out_drain, out_valid_o && out_ready_i && !ctrl.load_out, !out_valid_o)

endmodule

// File: sv/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer for clear pass, slot scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module art_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  art_pkg::stat_t stat_i,
  output art_pkg::ctrl_t ctrl_o
);
  import art_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.start    = 1'b1;
          ctrl_o.set_fail = stat_i.add_zero;
          state_d         = stat_i.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_en = 1'b1;
        if (stat_i.hit) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_FINISH;
        end else if (stat_i.miss_end) begin
          ctrl_o.set_fail = 1'b1;
          state_d         = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/art_datapath.sv
// ----------------------------------------------------------------------------
// art_datapath
// Range registers, slot memories, scan pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module art_datapath #(
  parameter int unsigned TINY_SLOTS  = 128,
  parameter int unsigned SMALL_SLOTS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [art_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [art_pkg::ADDR_W-1:0]        cfg_wdata_i,
  input  art_pkg::in_t                      in_data_i,
  input  art_pkg::ctrl_t                    ctrl_i,
  output art_pkg::stat_t                    stat_o,
  output art_pkg::out_t                     out_data_o
);
  import art_pkg::*;

  localparam int unsigned MAX_SLOTS = (TINY_SLOTS > SMALL_SLOTS) ? TINY_SLOTS : SMALL_SLOTS;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int unsigned TIDX_W    = $clog2(TINY_SLOTS);
  localparam int unsigned SIDX_W    = $clog2(SMALL_SLOTS);
  localparam int unsigned WORD_W    = ADDR_W + 1;

  localparam logic [CNT_W-1:0] TINY_N    = CNT_W'(TINY_SLOTS);
  localparam logic [CNT_W-1:0] SMALL_N   = CNT_W'(SMALL_SLOTS);
  localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(MAX_SLOTS - 1);
  localparam logic [IDX_W-1:0] TINY_LAST  = IDX_W'(TINY_SLOTS - 1);
  localparam logic [IDX_W-1:0] SMALL_LAST = IDX_W'(SMALL_SLOTS - 1);

  // range registers
  logic [ADDR_W-1:0] tiny_start_q, tiny_end_q, small_start_q, small_end_q;
  logic [ADDR_W-1:0] tiny_start_d, tiny_end_d, small_start_d, small_end_d;

  always_comb begin
    tiny_start_d  = tiny_start_q;
    tiny_end_d    = tiny_end_q;
    small_start_d = small_start_q;
    small_end_d   = small_end_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TINY_START:  tiny_start_d  = cfg_wdata_i;
        CFG_TINY_END:    tiny_end_d    = cfg_wdata_i;
        CFG_SMALL_START: small_start_d = cfg_wdata_i;
        CFG_SMALL_END:   small_end_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiny_start_q  <= '0;
      tiny_end_q    <= '0;
      small_start_q <= '0;
      small_end_q   <= '0;
    end else begin
      tiny_start_q  <= tiny_start_d;
      tiny_end_q    <= tiny_end_d;
      small_start_q <= small_start_d;
      small_end_q   <= small_end_d;
    end
  end

  // transaction capture
  logic [ADDR_W-1:0] rec_q;
  logic              cls_q, is_add_q, nz_q;
  logic              in_nz;

  assign in_nz = (in_data_i.user_addr != '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rec_q    <= in_data_i.user_addr - REC_OFFSET;
      cls_q    <= in_data_i.size_class;
      is_add_q <= (in_data_i.cmd == CMD_ADD);
      nz_q     <= in_nz;
    end
  end

  assign stat_o.need_scan = ((in_data_i.cmd == CMD_ADD) && in_nz) ||
                            (in_data_i.cmd == CMD_REMOVE);
  assign stat_o.add_zero  = (in_data_i.cmd == CMD_ADD) && !in_nz;

  // slot counter: clear sweep and scan issue
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_sel;
  logic [IDX_W-1:0] last_sel;
  logic             issue, hit;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  assign n_sel    = cls_q ? SMALL_N : TINY_N;
  assign last_sel = cls_q ? SMALL_LAST : TINY_LAST;
  assign issue    = ctrl_i.scan_en && (cnt_q < n_sel) && !hit;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.start) cnt_d = '0;
    else if (ctrl_i.clr_en || issue) cnt_d = cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) rd_idx_q <= cnt_q[IDX_W-1:0];
  end

  assign stat_o.clr_done = ctrl_i.clr_en && (cnt_q == CLR_LAST);

  // slot memories: {valid, record}
  logic [WORD_W-1:0] tiny_mem  [TINY_SLOTS];
  logic [WORD_W-1:0] small_mem [SMALL_SLOTS];
  logic [WORD_W-1:0] tiny_rd_q, small_rd_q, rd_word, wr_word;
  logic              tiny_we, small_we;
  logic [TIDX_W-1:0] tiny_waddr;
  logic [SIDX_W-1:0] small_waddr;

  assign wr_word     = ctrl_i.clr_en ? '0 : {is_add_q, rec_q};
  assign tiny_we     = (ctrl_i.clr_en && (cnt_q < TINY_N)) || (ctrl_i.commit && !cls_q);
  assign small_we    = (ctrl_i.clr_en && (cnt_q < SMALL_N)) || (ctrl_i.commit && cls_q);
  assign tiny_waddr  = ctrl_i.clr_en ? cnt_q[TIDX_W-1:0] : rd_idx_q[TIDX_W-1:0];
  assign small_waddr = ctrl_i.clr_en ? cnt_q[SIDX_W-1:0] : rd_idx_q[SIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (tiny_we) tiny_mem[tiny_waddr] <= wr_word;
    if (issue && !cls_q) tiny_rd_q <= tiny_mem[cnt_q[TIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (small_we) small_mem[small_waddr] <= wr_word;
    if (issue && cls_q) small_rd_q <= small_mem[cnt_q[SIDX_W-1:0]];
  end

  // slot compare
  logic match;

  assign rd_word = cls_q ? small_rd_q : tiny_rd_q;
  assign match   = is_add_q ? !rd_word[ADDR_W]
                            : (rd_word[ADDR_W] && (rd_word[ADDR_W-1:0] == rec_q));
  assign hit             = ctrl_i.scan_en && rd_vld_q && match;
  assign stat_o.hit      = hit;
  assign stat_o.miss_end = ctrl_i.scan_en && rd_vld_q && !match && (rd_idx_q == last_sel);

  // outcome
  logic             fail_q, fail_d;
  logic [IDX_W-1:0] slot_q, slot_d;

  always_comb begin
    fail_d = fail_q;
    slot_d = slot_q;
    if (ctrl_i.start) begin
      fail_d = 1'b0;
      slot_d = '0;
    end
    if (ctrl_i.set_fail) fail_d = 1'b1;
    if (ctrl_i.commit) slot_d = rd_idx_q;
  end

  always_ff @(posedge clk_i) begin
    fail_q <= fail_d;
    slot_q <= slot_d;
  end

  // result register
  logic                    in_range;
  logic [SLOT_W+IDX_W-1:0] slot_wide;
  out_t                    out_q;

  assign in_range  = nz_q &&
                     (((rec_q >= tiny_start_q) && (rec_q <= tiny_end_q)) ||
                      ((rec_q >= small_start_q) && (rec_q <= small_end_q)));
  assign slot_wide = {{SLOT_W{1'b0}}, slot_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q.status      <= fail_q;
      out_q.slot_index  <= fail_q ? '0 : slot_wide[SLOT_W-1:0];
      out_q.in_range    <= in_range;
      out_q.record_addr <= in_range ? rec_q : '0;
    end
  end

  assign out_data_o = out_q;

endmodule
